>>> hdl/bcpe_pkg.sv
// Shared constants, codes and the binomial helper for the Bezier point evaluator.
package bcpe_pkg;

	// Default size of the control point store and the fraction width of t.
	localparam int MAX_POINTS_DEF  = 8;
	localparam int T_FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COORD_W  = 16;
	localparam int OUT_W    = 24;
	localparam int ACTIVE_W = 4;

	// Width of the largest binomial coefficient for up to sixteen points.
	localparam int BINOM_W = 13;

	// Reset value of the active point count.
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd4;

	// Item action codes.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// Binomial coefficient C(m, k) built from Pascal's triangle.
	function automatic int binom(input int m, input int k);
		int row [17];
		int r;
		int j;
		for (j = 0; j < 17; j++) begin
			row[j] = 0;
		end
		row[0] = 1;
		for (r = 1; r <= m; r++) begin
			for (j = 16; j >= 1; j--) begin
				if (j <= r) begin
					row[j] = row[j] + row[j-1];
				end
			end
		end
		return row[k];
	endfunction

endpackage

>>> hdl/bezier_curve_point_evaluator_unit.sv
// Top level of the pipelined Bezier curve point evaluator.
// A load item writes one control point into the store and gives no result; an evaluate item
// returns one point per item, and a new item is taken on every cycle that the output is free
// or being taken. An evaluate result passes through MAX_POINTS - 1 stages in the power chain
// of t and (1-t), then the weight stage, the term stage, the adder tree levels and the output
// register. Points are snapshotted when the evaluate item is accepted, so later loads never
// affect it. Write active_points only while the pipeline is empty.
module bezier_curve_point_evaluator_unit #(
	parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
	parameter int T_FRAC_BITS = bcpe_pkg::T_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bcpe_pkg::ACTIVE_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [2:0]                        point_index,
	input  logic signed [bcpe_pkg::COORD_W-1:0] point_x,
	input  logic signed [bcpe_pkg::COORD_W-1:0] point_y,
	input  logic [T_FRAC_BITS:0]              t_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bcpe_pkg::OUT_W-1:0] curve_x,
	output logic signed [bcpe_pkg::OUT_W-1:0] curve_y
);

	localparam int CW  = bcpe_pkg::COORD_W;
	localparam int BW  = bcpe_pkg::BINOM_W;
	localparam int OW  = bcpe_pkg::OUT_W;
	localparam int PW  = T_FRAC_BITS + 1;
	localparam int NW  = $clog2(MAX_POINTS + 1);
	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CH  = MAX_POINTS - 1;
	localparam int LV  = $clog2(MAX_POINTS);
	localparam int L   = 1 << LV;
	localparam int PBW = CW + BW + 1;
	localparam int TW  = PBW + PW + 1;
	localparam int SW  = TW + LV;
	localparam int SH  = T_FRAC_BITS - 8;
	localparam logic [PW-1:0] ONE = PW'(1) << T_FRAC_BITS;

	logic en;
	logic in_acc;

	// Configuration register.
	logic [bcpe_pkg::ACTIVE_W-1:0] active_points_q;
	logic [NW-1:0]                 n_eff;

	// Control point store.
	logic signed [CW-1:0] ctrl_x_q [MAX_POINTS];
	logic signed [CW-1:0] ctrl_y_q [MAX_POINTS];

	// Binomial table, row n-1.
	logic [BW-1:0] binom_tab [MAX_POINTS][MAX_POINTS];

	// Power chain registers, one element per chain stage.
	logic                 v_pow_s  [CH];
	logic [NW-1:0]        n_pow_s  [CH];
	logic [PW-1:0]        pt_pow_s [CH][MAX_POINTS];
	logic [PW-1:0]        pu_pow_s [CH][MAX_POINTS];
	logic signed [CW-1:0] px_pow_s [CH][MAX_POINTS];
	logic signed [CW-1:0] py_pow_s [CH][MAX_POINTS];

	// Weight stage.
	logic                  v_w_s;
	logic [PW-1:0]         prod_w_s [MAX_POINTS];
	logic signed [PBW-1:0] pbx_w_s  [MAX_POINTS];
	logic signed [PBW-1:0] pby_w_s  [MAX_POINTS];

	// Adder tree, level zero holds the terms.
	logic                 v_tree_s  [LV+1];
	logic signed [SW-1:0] sx_tree_s [LV+1][L];
	logic signed [SW-1:0] sy_tree_s [LV+1][L];

	// Output register.
	logic                 out_valid_q;
	logic signed [OW-1:0] cx_q;
	logic signed [OW-1:0] cy_q;

	logic [PW-1:0]        t_sat;
	logic signed [SW-1:0] rx;
	logic signed [SW-1:0] ry;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && en;
	assign out_valid = out_valid_q;
	assign curve_x   = cx_q;
	assign curve_y   = cy_q;

	// Point count saturated to the store depth.
	always_comb begin
		if (NW'(active_points_q) > NW'(MAX_POINTS)) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = NW'(active_points_q);
		end
	end

	// Curve parameter saturated to one.
	assign t_sat = (t_value > ONE) ? ONE : t_value;

	// Constant binomial table.
	for (genvar m = 0; m < MAX_POINTS; m++) begin : g_brow
		for (genvar k = 0; k < MAX_POINTS; k++) begin : g_bcol
			assign binom_tab[m][k] = BW'(bcpe_pkg::binom(m, k));
		end
	end

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_points_q <= bcpe_pkg::ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_points_q <= cfg_data;
		end
	end

	// Load items write one store entry; indexes beyond the store are dropped.
	always_ff @(posedge clk) begin
		for (int e = 0; e < MAX_POINTS; e++) begin
			if (in_acc && action == bcpe_pkg::ACT_LOAD && 32'(point_index) == e) begin
				ctrl_x_q[e] <= point_x;
				ctrl_y_q[e] <= point_y;
			end
		end
	end

	// First chain stage: powers zero and one, point snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_pow_s[0] <= 1'b0;
		end else if (en) begin
			v_pow_s[0] <= in_valid && action == bcpe_pkg::ACT_EVAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_pow_s[0] <= n_eff;
			for (int e = 0; e < MAX_POINTS; e++) begin
				if (e == 0) begin
					pt_pow_s[0][e] <= ONE;
					pu_pow_s[0][e] <= ONE;
				end else if (e == 1) begin
					pt_pow_s[0][e] <= t_sat;
					pu_pow_s[0][e] <= ONE - t_sat;
				end else begin
					pt_pow_s[0][e] <= '0;
					pu_pow_s[0][e] <= '0;
				end
				px_pow_s[0][e] <= ctrl_x_q[e];
				py_pow_s[0][e] <= ctrl_y_q[e];
			end
		end
	end

	// Each further chain stage forms the next power of t and of (1-t), truncated.
	for (genvar j = 1; j < CH; j++) begin : g_chain
		logic [2*PW-1:0] mt;
		logic [2*PW-1:0] mu;

		assign mt = {{PW{1'b0}}, pt_pow_s[j-1][j]} * {{PW{1'b0}}, pt_pow_s[j-1][1]};
		assign mu = {{PW{1'b0}}, pu_pow_s[j-1][j]} * {{PW{1'b0}}, pu_pow_s[j-1][1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_pow_s[j] <= 1'b0;
			end else if (en) begin
				v_pow_s[j] <= v_pow_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_pow_s[j] <= n_pow_s[j-1];
				for (int e = 0; e < MAX_POINTS; e++) begin
					if (e == j + 1) begin
						pt_pow_s[j][e] <= mt[T_FRAC_BITS +: PW];
						pu_pow_s[j][e] <= mu[T_FRAC_BITS +: PW];
					end else begin
						pt_pow_s[j][e] <= pt_pow_s[j-1][e];
						pu_pow_s[j][e] <= pu_pow_s[j-1][e];
					end
					px_pow_s[j][e] <= px_pow_s[j-1][e];
					py_pow_s[j][e] <= py_pow_s[j-1][e];
				end
			end
		end
	end

	// Weight stage: power product per point and point times binomial.
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_weight
		logic [NW-1:0]   ui_full;
		logic [IW-1:0]   ui;
		logic [IW-1:0]   bi;
		logic [2*PW-1:0] pp;
		logic [BW-1:0]   bc;
		logic            act;

		assign act     = NW'(i) < n_pow_s[CH-1];
		assign ui_full = n_pow_s[CH-1] - NW'(1) - NW'(i);
		assign ui      = ui_full[IW-1:0];
		assign bi      = ui_full[IW-1:0] + IW'(i);
		assign pp      = {{PW{1'b0}}, pt_pow_s[CH-1][i]} * {{PW{1'b0}}, pu_pow_s[CH-1][ui]};
		assign bc      = binom_tab[bi][i];

		always_ff @(posedge clk) begin
			if (en) begin
				prod_w_s[i] <= act ? pp[T_FRAC_BITS +: PW] : '0;
				pbx_w_s[i]  <= PBW'(px_pow_s[CH-1][i]) * PBW'($signed({1'b0, bc}));
				pby_w_s[i]  <= PBW'(py_pow_s[CH-1][i]) * PBW'($signed({1'b0, bc}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w_s <= 1'b0;
		end else if (en) begin
			v_w_s <= v_pow_s[CH-1];
		end
	end

	// Term stage: weighted coordinates, the leaves of the adder tree.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < L; i++) begin
				if (i < MAX_POINTS) begin
					sx_tree_s[0][i] <= SW'(pbx_w_s[i]) * SW'($signed({1'b0, prod_w_s[i]}));
					sy_tree_s[0][i] <= SW'(pby_w_s[i]) * SW'($signed({1'b0, prod_w_s[i]}));
				end else begin
					sx_tree_s[0][i] <= '0;
					sy_tree_s[0][i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_tree_s[0] <= 1'b0;
		end else if (en) begin
			v_tree_s[0] <= v_w_s;
		end
	end

	// Registered pairwise adder tree.
	for (genvar l = 1; l <= LV; l++) begin : g_tree
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_tree_s[l] <= 1'b0;
			end else if (en) begin
				v_tree_s[l] <= v_tree_s[l-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < L; k++) begin
					if (k < (L >> l)) begin
						sx_tree_s[l][k] <= sx_tree_s[l-1][2*k] + sx_tree_s[l-1][2*k+1];
						sy_tree_s[l][k] <= sy_tree_s[l-1][2*k] + sy_tree_s[l-1][2*k+1];
					end else begin
						sx_tree_s[l][k] <= '0;
						sy_tree_s[l][k] <= '0;
					end
				end
			end
		end
	end

	// Floor to eight fraction bits.
	assign rx = sx_tree_s[LV][0] >>> SH;
	assign ry = sy_tree_s[LV][0] >>> SH;

	// Output register with saturation to the 24-bit range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_tree_s[LV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (&rx[SW-1:OW-1] || ~|rx[SW-1:OW-1]) begin
				cx_q <= rx[OW-1:0];
			end else begin
				cx_q <= rx[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
			end
			if (&ry[SW-1:OW-1] || ~|ry[SW-1:OW-1]) begin
				cy_q <= ry[OW-1:0];
			end else begin
				cy_q <= ry[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
			end
		end
	end

	// A load item never enters the pipeline.
	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == bcpe_pkg::ACT_LOAD |=> !v_pow_s[0])
		else $error("load item entered the evaluation pipeline");

	// While stalled, the first stage and the last tree level keep their items.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_pow_s[0]) && $stable(v_tree_s[LV]))
		else $error("pipeline moved during a stall");

	// A new result comes only from the last tree level.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_tree_s[LV]))
		else $error("result appeared without an item in the tree");

endmodule
